### src/bce_pkg.sv
// Shared types and constants for the betweenness centrality engine.
// No dependencies.
package bce_pkg;

    localparam int MAX_NODES  = 64;
    localparam int NODE_BITS  = 6;
    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 48;
    localparam int HOP_BITS   = 7;
    localparam int ACC_BITS   = 32;
    localparam int SCORE_BITS = 27;
    localparam int NCNT_BITS  = 7;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_CLEAR   = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]           command;
        logic [NODE_BITS-1:0] node_a;
        logic [NODE_BITS-1:0] node_b;
    } bce_in_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]  node_index;
        logic [SCORE_BITS-1:0] score;
        logic                  count_saturated;
        logic                  last;
    } bce_out_t;

    // Per-node working word: hop distance, path count, dependency.
    typedef struct packed {
        logic [HOP_BITS-1:0]   hop;
        logic [COUNT_BITS-1:0] cnt;
        logic [ACC_BITS-1:0]   dep;
    } bce_node_t;

endpackage

### src/bce_frac_div.sv
// Iterative fraction divider: q = floor(a * 2^FRAC_BITS / b) for a < b,
// one quotient bit per cycle. Depends on bce_pkg.
module bce_frac_div
    import bce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] num,
    input  logic [COUNT_BITS-1:0] den,
    output logic                  done,
    output logic [FRAC_BITS:0]    quot
);

    localparam int STEP_BITS = $clog2(FRAC_BITS + 1);

    logic                  busy_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [COUNT_BITS-1:0] den_reg;
    logic [FRAC_BITS-1:0]  q_reg;
    logic                  done_reg;
    logic [FRAC_BITS:0]    quot_reg;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  take;

    assign rem_sh = {rem_reg[COUNT_BITS-1:0], 1'b0};
    assign take   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    quot_reg <= '0;
                    done_reg <= 1'b1;
                end
                else if (num >= den)
                begin
                    quot_reg <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= {1'b0, num};
                    den_reg  <= den;
                    q_reg    <= '0;
                    step_reg <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= take ? rem_sh - {1'b0, den_reg} : rem_sh;
                q_reg    <= {q_reg[FRAC_BITS-2:0], take};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= {1'b0, q_reg[FRAC_BITS-2:0], take};
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### src/betweenness_centrality_engine.sv
// Betweenness centrality engine top level: sequencer, graph and node memories.
// Depends on bce_pkg and bce_frac_div.
//
// Keeps an undirected friendship graph of up to 64 nodes as a 64 x 64 bit
// memory with one valid bit per row, so a clear only resets the valid bits.
// An add does a read-modify-write of both rows. A compute runs Brandes
// betweenness over nodes 0..n-1, n = min(node_count, 64): it first zeroes the
// n score accumulators, then per source does a breadth-first count of
// shortest paths and a reverse dependency pass. Both passes scan n candidate
// neighbors per node, and each dependency term also waits on the single
// shared fraction divider and multiplier. Scores then leave one per transfer,
// ascending node index, each held until out_ready. in_ready is low for the
// whole run. Path counts saturate at 2^48-1 and raise count_saturated on every
// result of that run; dependencies and accumulators saturate at 2^32-1 and
// the halved score at 2^27-1. node_count may be written any time the block is
// idle.
module betweenness_centrality_engine
    import bce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bce_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output bce_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [NCNT_BITS-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ADD_WA, ST_ADD_RB, ST_ADD_WB, ST_ACC_CLR, ST_SRC_INIT,
        ST_DEQ, ST_DEQ_V, ST_LOAD_V, ST_SCAN, ST_FWD_UPD,
        ST_REV, ST_REV_W, ST_REV_LOAD, ST_RSCAN, ST_RCHK, ST_RDIV, ST_RMUL,
        ST_RWR, ST_ACC_UPD, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_OUT
    } state_t;

    localparam logic [ACC_BITS-1:0]   ACC_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
    localparam int PROD_BITS = ACC_BITS + 2;

    // Control and datapath registers
    state_t                state_reg, state_next;
    logic [NCNT_BITS-1:0]  node_count_reg;
    logic [NCNT_BITS-1:0]  n_reg, n_next;
    logic [NCNT_BITS-1:0]  idx_reg, idx_next;
    logic [NCNT_BITS-1:0]  head_reg, head_next;
    logic [NCNT_BITS-1:0]  tail_reg, tail_next;
    logic [NCNT_BITS-1:0]  rev_reg, rev_next;
    logic [NCNT_BITS-1:0]  src_reg, src_next;
    logic [MAX_NODES-1:0]  visited_reg, visited_next;
    logic [MAX_NODES-1:0]  nb_reg, nb_next;
    bce_node_t             cur_reg, cur_next;
    logic [NODE_BITS-1:0]  cur_id_reg, cur_id_next;
    bce_node_t             oth_reg, oth_next;
    logic [FRAC_BITS:0]    f_reg, f_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic                  sat_reg, sat_next;
    logic [NODE_BITS-1:0]  add_b_reg, add_b_next;
    logic                  out_valid_reg, out_valid_next;
    bce_out_t              out_reg, out_next;

    // Memories: friendship rows, node words, discovery order, accumulators
    logic [MAX_NODES-1:0]  fm_mem [MAX_NODES];
    logic [MAX_NODES-1:0]  row_valid_reg;
    logic [MAX_NODES-1:0]  fm_rdata_reg;
    logic                  fm_rvalid_reg;
    logic [MAX_NODES-1:0]  fm_row;
    logic [NODE_BITS-1:0]  fm_raddr, fm_waddr;
    logic                  fm_we, fm_clear;
    logic [MAX_NODES-1:0]  fm_wdata;

    bce_node_t             nd_mem [MAX_NODES];
    bce_node_t             nd_rdata_reg;
    logic [NODE_BITS-1:0]  nd_raddr, nd_waddr;
    logic                  nd_we;
    bce_node_t             nd_wdata;

    logic [NODE_BITS-1:0]  ord_mem [MAX_NODES];
    logic [NODE_BITS-1:0]  ord_rdata_reg;
    logic [NODE_BITS-1:0]  ord_raddr, ord_waddr, ord_wdata;
    logic                  ord_we;

    logic [ACC_BITS-1:0]   acc_mem [MAX_NODES];
    logic [ACC_BITS-1:0]   acc_rdata_reg;
    logic [NODE_BITS-1:0]  acc_raddr, acc_waddr;
    logic                  acc_we;
    logic [ACC_BITS-1:0]   acc_wdata;

    // Shared arithmetic
    logic                  div_start, div_done;
    logic [FRAC_BITS:0]    div_q;
    logic [ACC_BITS:0]     mult;
    logic [FRAC_BITS+ACC_BITS+1:0] mul_full;
    logic [COUNT_BITS:0]   cnt_sum;
    logic [PROD_BITS:0]    dep_sum;
    logic [ACC_BITS:0]     acc_sum;
    logic [ACC_BITS-2:0]   half_acc;
    logic [HOP_BITS-1:0]   hop_inc;

    bce_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (nd_rdata_reg.cnt),
        .den   (cur_reg.cnt),
        .done  (div_done),
        .quot  (div_q)
    );

    assign fm_row   = fm_rvalid_reg ? fm_rdata_reg : '0;
    assign mult     = {1'b0, cur_reg.dep} + ((ACC_BITS+1)'(1) << FRAC_BITS);
    assign mul_full = f_reg * mult;
    assign hop_inc  = cur_reg.hop + 1'b1;
    assign cnt_sum  = {1'b0, nd_rdata_reg.cnt} + {1'b0, cur_reg.cnt};
    assign dep_sum  = (PROD_BITS+1)'(oth_reg.dep) + (PROD_BITS+1)'(prod_reg);
    assign acc_sum  = {1'b0, acc_rdata_reg} + {1'b0, cur_reg.dep};
    assign half_acc = acc_rdata_reg[ACC_BITS-1:1];

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rev_next       = rev_reg;
        src_next       = src_reg;
        visited_next   = visited_reg;
        nb_next        = nb_reg;
        cur_next       = cur_reg;
        cur_id_next    = cur_id_reg;
        oth_next       = oth_reg;
        f_next         = f_reg;
        prod_next      = mul_full[FRAC_BITS +: PROD_BITS];
        sat_next       = sat_reg;
        add_b_next     = add_b_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        fm_raddr  = idx_reg[NODE_BITS-1:0];
        fm_we     = 1'b0;
        fm_clear  = 1'b0;
        fm_waddr  = cur_id_reg;
        fm_wdata  = fm_row;
        nd_raddr  = idx_reg[NODE_BITS-1:0];
        nd_we     = 1'b0;
        nd_waddr  = idx_reg[NODE_BITS-1:0];
        nd_wdata  = nd_rdata_reg;
        ord_raddr = head_reg[NODE_BITS-1:0];
        ord_we    = 1'b0;
        ord_waddr = tail_reg[NODE_BITS-1:0];
        ord_wdata = idx_reg[NODE_BITS-1:0];
        acc_raddr = idx_reg[NODE_BITS-1:0];
        acc_we    = 1'b0;
        acc_waddr = idx_reg[NODE_BITS-1:0];
        acc_wdata = '0;
        div_start = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                fm_raddr = in_data.node_a;
                if (in_valid)
                begin
                    case (in_data.command)
                        CMD_ADD:
                        begin
                            cur_id_next = in_data.node_a;
                            add_b_next  = in_data.node_b;
                            state_next  = ST_ADD_WA;
                        end
                        CMD_CLEAR:
                        begin
                            fm_clear = 1'b1;
                        end
                        CMD_COMPUTE:
                        begin
                            n_next   = (node_count_reg > NCNT_BITS'(MAX_NODES)) ?
                                       NCNT_BITS'(MAX_NODES) : node_count_reg;
                            idx_next = '0;
                            sat_next = 1'b0;
                            if (node_count_reg != '0)
                            begin
                                state_next = ST_ACC_CLR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD_WA:
            begin
                fm_we      = 1'b1;
                fm_wdata   = fm_row | (MAX_NODES'(1) << add_b_reg);
                state_next = ST_ADD_RB;
            end
            ST_ADD_RB:
            begin
                fm_raddr   = add_b_reg;
                state_next = ST_ADD_WB;
            end
            ST_ADD_WB:
            begin
                fm_we      = 1'b1;
                fm_waddr   = add_b_reg;
                fm_wdata   = fm_row | (MAX_NODES'(1) << cur_id_reg);
                state_next = ST_IDLE;
            end
            ST_ACC_CLR:
            begin
                acc_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_reg - 1'b1)
                begin
                    src_next   = '0;
                    state_next = ST_SRC_INIT;
                end
            end
            ST_SRC_INIT:
            begin
                nd_we        = 1'b1;
                nd_waddr     = src_reg[NODE_BITS-1:0];
                nd_wdata     = '{hop: '0, cnt: COUNT_BITS'(1), dep: '0};
                ord_we       = 1'b1;
                ord_waddr    = '0;
                ord_wdata    = src_reg[NODE_BITS-1:0];
                visited_next = MAX_NODES'(1) << src_reg[NODE_BITS-1:0];
                head_next    = '0;
                tail_next    = NCNT_BITS'(1);
                state_next   = ST_DEQ;
            end
            ST_DEQ:
            begin
                if (head_reg == tail_reg)
                begin
                    rev_next   = tail_reg;
                    state_next = ST_REV;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_DEQ_V;
                end
            end
            ST_DEQ_V:
            begin
                fm_raddr    = ord_rdata_reg;
                nd_raddr    = ord_rdata_reg;
                cur_id_next = ord_rdata_reg;
                state_next  = ST_LOAD_V;
            end
            ST_LOAD_V:
            begin
                cur_next   = nd_rdata_reg;
                nb_next    = fm_row;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = ST_DEQ;
                end
                else if (nb_reg[idx_reg[NODE_BITS-1:0]])
                begin
                    state_next = ST_FWD_UPD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FWD_UPD:
            begin
                // First sighting: new layer, inherit the parent's count.
                if (!visited_reg[idx_reg[NODE_BITS-1:0]])
                begin
                    visited_next[idx_reg[NODE_BITS-1:0]] = 1'b1;
                    nd_we     = 1'b1;
                    nd_wdata  = '{hop: hop_inc, cnt: cur_reg.cnt, dep: '0};
                    ord_we    = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                else if (nd_rdata_reg.hop == hop_inc)
                begin
                    nd_we        = 1'b1;
                    nd_wdata.cnt = cnt_sum[COUNT_BITS] ? COUNT_MAX :
                                   cnt_sum[COUNT_BITS-1:0];
                    if (cnt_sum[COUNT_BITS])
                    begin
                        sat_next = 1'b1;
                    end
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SCAN;
            end
            ST_REV:
            begin
                if (rev_reg == '0)
                begin
                    src_next = src_reg + 1'b1;
                    idx_next = '0;
                    if (src_reg == n_reg - 1'b1)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_SRC_INIT;
                    end
                end
                else
                begin
                    ord_raddr  = rev_reg[NODE_BITS-1:0] - 1'b1;
                    rev_next   = rev_reg - 1'b1;
                    state_next = ST_REV_W;
                end
            end
            ST_REV_W:
            begin
                fm_raddr    = ord_rdata_reg;
                nd_raddr    = ord_rdata_reg;
                cur_id_next = ord_rdata_reg;
                state_next  = ST_REV_LOAD;
            end
            ST_REV_LOAD:
            begin
                cur_next   = nd_rdata_reg;
                nb_next    = fm_row & visited_reg;
                idx_next   = '0;
                state_next = ST_RSCAN;
            end
            ST_RSCAN:
            begin
                if (idx_reg == n_reg)
                begin
                    acc_raddr = cur_id_reg;
                    if (NCNT_BITS'(cur_id_reg) != src_reg)
                    begin
                        state_next = ST_ACC_UPD;
                    end
                    else
                    begin
                        state_next = ST_REV;
                    end
                end
                else if (nb_reg[idx_reg[NODE_BITS-1:0]])
                begin
                    state_next = ST_RCHK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RCHK:
            begin
                // Only predecessors one layer closer to the source contribute.
                oth_next = nd_rdata_reg;
                if (HOP_BITS'(nd_rdata_reg.hop + 1'b1) == cur_reg.hop)
                begin
                    div_start  = 1'b1;
                    state_next = ST_RDIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RSCAN;
                end
            end
            ST_RDIV:
            begin
                if (div_done)
                begin
                    f_next     = div_q;
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL:
            begin
                state_next = ST_RWR;
            end
            ST_RWR:
            begin
                nd_we        = 1'b1;
                nd_wdata     = oth_reg;
                nd_wdata.dep = (dep_sum > (PROD_BITS+1)'(ACC_MAX)) ? ACC_MAX :
                               dep_sum[ACC_BITS-1:0];
                idx_next     = idx_reg + 1'b1;
                state_next   = ST_RSCAN;
            end
            ST_ACC_UPD:
            begin
                acc_we     = 1'b1;
                acc_waddr  = cur_id_reg;
                acc_wdata  = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
                state_next = ST_REV;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_next.node_index      = idx_reg[NODE_BITS-1:0];
                out_next.score           = (half_acc > (ACC_BITS-1)'(SCORE_MAX)) ?
                                           SCORE_MAX : half_acc[SCORE_BITS-1:0];
                out_next.count_saturated = sat_reg;
                out_next.last            = (idx_reg == n_reg - 1'b1);
                out_valid_next           = 1'b1;
                state_next               = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == n_reg - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NCNT_BITS'(MAX_NODES);
            out_valid_reg  <= 1'b0;
            row_valid_reg  <= '0;
            n_reg          <= '0;
            idx_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            rev_reg        <= '0;
            src_reg        <= '0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rev_reg       <= rev_next;
            src_reg       <= src_next;
            sat_reg       <= sat_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            if (fm_clear)
            begin
                row_valid_reg <= '0;
            end
            else if (fm_we)
            begin
                row_valid_reg[fm_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        visited_reg <= visited_next;
        nb_reg      <= nb_next;
        cur_reg     <= cur_next;
        cur_id_reg  <= cur_id_next;
        oth_reg     <= oth_next;
        f_reg       <= f_next;
        prod_reg    <= prod_next;
        add_b_reg   <= add_b_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fm_mem[fm_waddr] <= fm_wdata;
        end
        fm_rdata_reg  <= fm_mem[fm_raddr];
        fm_rvalid_reg <= row_valid_reg[fm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            nd_mem[nd_waddr] <= nd_wdata;
        end
        nd_rdata_reg <= nd_mem[nd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata_reg <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rdata_reg <= acc_mem[acc_raddr];
    end

endmodule
